### rtl/otst_pkg.sv
// Package for the one-shot timer table: slot record, command record,
// command and status codes. No dependencies.
`default_nettype none

package otst_pkg;

  localparam int MAX_RESULTS = 8;
  localparam int CNT_W = 4;

  localparam logic [2:0] REQ_ADD    = 3'd0;
  localparam logic [2:0] REQ_MODIFY = 3'd1;
  localparam logic [2:0] REQ_START  = 3'd2;
  localparam logic [2:0] REQ_DELETE = 3'd3;
  localparam logic [2:0] REQ_TICK   = 3'd4;

  localparam logic [2:0] RC_OK         = 3'd0;
  localparam logic [2:0] RC_BAD_PARAM  = 3'd1;
  localparam logic [2:0] RC_BAD_HANDLE = 3'd2;
  localparam logic [2:0] RC_NO_TIMER   = 3'd3;
  localparam logic [2:0] RC_NOT_READY  = 3'd4;

  typedef enum logic [1:0] {
    SLOT_IDLE  = 2'd0,
    SLOT_READY = 2'd1,
    SLOT_RUN   = 2'd2
  } slot_state_t;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_PASS,
    FSM_FINISH
  } fsm_t;

  typedef struct packed {
    slot_state_t state;
    logic [31:0] ticks;
    logic [31:0] cb;
    logic [31:0] tag;
  } slot_t;

  typedef struct packed {
    logic [2:0]  req;
    logic [7:0]  idx;
    logic [31:0] ticks;
    logic [31:0] cb;
    logic [31:0] tag;
  } cmd_t;

  // what the update unit reports about the slot it just handled
  typedef struct packed {
    logic       hit;
    logic [2:0] status;
    logic       expire;
  } proc_evt_t;

endpackage

`default_nettype wire

### rtl/otst_cell.sv
// One timer slot of the ring. Takes its neighbor's record each cycle
// while the ring turns. Depends on otst_pkg.
`default_nettype none

module otst_cell import otst_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  shift_en,
  input  wire slot_t slot_in,
  output slot_t      slot_out
);

  slot_t slot;

  always_ff @(posedge clk) begin
    if (shift_en) begin
      slot <= slot_in;
    end
    if (rst) begin
      slot.state <= SLOT_IDLE;
    end
  end

  assign slot_out = slot;

endmodule

`default_nettype wire

### rtl/otst_proc.sv
// Slot update unit: applies the current command to the record leaving
// the head of the ring. Depends on otst_pkg.
`default_nettype none

module otst_proc import otst_pkg::*; (
  input  wire cmd_t       cmd,
  input  wire logic [7:0] slot_idx,
  input  wire logic       add_done,
  input  wire logic       cnt_full,
  input  wire slot_t      slot_in,
  output slot_t           slot_out,
  output proc_evt_t       evt
);

  logic        match;
  logic [31:0] dec;

  assign match = (slot_idx == cmd.idx);
  assign dec   = slot_in.ticks - 32'd1;

  always_comb begin
    slot_out   = slot_in;
    evt.hit    = 1'b0;
    evt.status = RC_OK;
    evt.expire = 1'b0;
    case (cmd.req)
      REQ_ADD: begin
        if (cmd.cb != 32'd0 && !add_done && slot_in.state == SLOT_IDLE) begin
          slot_out.state = SLOT_READY;
          slot_out.ticks = cmd.ticks;
          slot_out.cb    = cmd.cb;
          slot_out.tag   = cmd.tag;
          evt.hit        = 1'b1;
        end
      end
      REQ_MODIFY: begin
        if (match) begin
          evt.hit = 1'b1;
          if (slot_in.state == SLOT_IDLE) begin
            evt.status = RC_NO_TIMER;
          end else begin
            slot_out.ticks = cmd.ticks;
          end
        end
      end
      REQ_START: begin
        if (match) begin
          evt.hit = 1'b1;
          if (slot_in.state != SLOT_READY) begin
            evt.status = RC_NOT_READY;
          end else begin
            slot_out.state = SLOT_RUN;
          end
        end
      end
      REQ_DELETE: begin
        if (match) begin
          evt.hit = 1'b1;
          if (slot_in.state == SLOT_IDLE) begin
            evt.status = RC_BAD_HANDLE;
          end else begin
            slot_out.state = SLOT_IDLE;
          end
        end
      end
      REQ_TICK: begin
        // once the expiry budget is spent, a slot about to hit zero waits
        if (slot_in.state == SLOT_RUN && !(slot_in.ticks == 32'd1 && cnt_full)) begin
          slot_out.ticks = dec;
          if (dec == 32'd0) begin
            slot_out.state = SLOT_IDLE;
            evt.expire     = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

### rtl/one_shot_timer_table.sv
// Channel  | Handshake                 | Beat
// ---------+---------------------------+---------------------------------------------
// command  | start & !busy             | req_type timer_index tick_count callback_id
//          |                           | user_tag
// result   | result_valid (one cycle)  | status_code is_expiry result_index
//          |                           | expired_callback expired_tag last_result
//
// Each command turns the ring of TIMER_SLOTS cells once through the slot update
// unit while busy is high; the next command is taken only once busy is low. An
// expiry is held until the next one is found and goes out the cycle after that;
// the final beat shows in the first cycle with busy low. Reset returns all
// slots to idle. Results cannot be held off by the receiver.
// Depends on otst_pkg, otst_cell, otst_proc.
`default_nettype none

module one_shot_timer_table import otst_pkg::*; #(
  parameter int TIMER_SLOTS = 8
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [2:0]  req_type,
  input  wire logic [7:0]  timer_index,
  input  wire logic [31:0] tick_count,
  input  wire logic [31:0] callback_id,
  input  wire logic [31:0] user_tag,
  output logic             result_valid,
  output logic [2:0]       status_code,
  output logic             is_expiry,
  output logic [7:0]       result_index,
  output logic [31:0]      expired_callback,
  output logic [31:0]      expired_tag,
  output logic             last_result
);

  localparam int IW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
  localparam logic [IW-1:0] LAST_STEP = IW'(TIMER_SLOTS - 1);

  fsm_t            fsm, fsm_next;
  cmd_t            cmd;
  logic [IW-1:0]   step;
  logic            add_done;
  logic [2:0]      status;
  logic [7:0]      res_index;
  logic [CNT_W-1:0] exp_cnt;
  logic            pend;
  logic [7:0]      pend_index;
  logic [31:0]     pend_cb;
  logic [31:0]     pend_tag;

  logic            accept;
  logic            shift_en;
  logic            cnt_full;
  slot_t           cell_q [TIMER_SLOTS];
  slot_t           proc_out;
  proc_evt_t       evt;

  assign accept   = start && !busy;
  assign shift_en = (fsm == FSM_PASS);
  assign cnt_full = (exp_cnt >= CNT_W'(MAX_RESULTS));

  // ring: cell i takes cell i+1, the tail takes the updated head record
  for (genvar i = 0; i < TIMER_SLOTS; i++) begin : g_cell
    slot_t cell_in;
    if (i == TIMER_SLOTS - 1) begin : g_tail
      assign cell_in = proc_out;
    end else begin : g_mid
      assign cell_in = cell_q[i+1];
    end
    otst_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .shift_en (shift_en),
      .slot_in  (cell_in),
      .slot_out (cell_q[i])
    );
  end

  otst_proc u_proc (
    .cmd      (cmd),
    .slot_idx (8'(step)),
    .add_done (add_done),
    .cnt_full (cnt_full),
    .slot_in  (cell_q[0]),
    .slot_out (proc_out),
    .evt      (evt)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      fsm <= FSM_IDLE;
    end else begin
      fsm <= fsm_next;
    end
  end

  always_comb begin
    fsm_next = fsm;
    busy     = 1'b1;
    case (fsm)
      FSM_IDLE: begin
        busy = 1'b0;
        if (start) begin
          fsm_next = FSM_PASS;
        end
      end
      FSM_PASS: begin
        if (step == LAST_STEP) begin
          fsm_next = FSM_FINISH;
        end
      end
      FSM_FINISH: begin
        fsm_next = FSM_IDLE;
      end
      default: begin
        fsm_next = FSM_IDLE;
      end
    endcase
  end

  // command bookkeeping
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd.req   <= req_type;
      cmd.idx   <= timer_index;
      cmd.ticks <= tick_count;
      cmd.cb    <= callback_id;
      cmd.tag   <= user_tag;
      step      <= '0;
      add_done  <= 1'b0;
      res_index <= 8'd0;
      exp_cnt   <= '0;
      pend      <= 1'b0;
      case (req_type)
        REQ_ADD: begin
          status <= (callback_id == 32'd0) ? RC_BAD_PARAM : RC_NO_TIMER;
        end
        REQ_MODIFY, REQ_START, REQ_DELETE: begin
          status <= (timer_index >= 8'(TIMER_SLOTS)) ? RC_BAD_HANDLE : RC_OK;
        end
        REQ_TICK: begin
          status <= RC_OK;
        end
        default: begin
          status <= RC_BAD_PARAM;
        end
      endcase
    end else if (fsm == FSM_PASS) begin
      step <= step + IW'(1);
      if (evt.hit) begin
        status <= evt.status;
        if (cmd.req == REQ_ADD) begin
          add_done  <= 1'b1;
          res_index <= 8'(step);
        end
      end
      if (evt.expire) begin
        exp_cnt    <= exp_cnt + CNT_W'(1);
        pend       <= 1'b1;
        pend_index <= 8'(step);
        pend_cb    <= cell_q[0].cb;
        pend_tag   <= cell_q[0].tag;
      end
    end
    if (rst) begin
      pend     <= 1'b0;
      add_done <= 1'b0;
      exp_cnt  <= '0;
    end
  end

  // result register: a held expiry goes out when the next one shows up,
  // the last one, or else the status beat, at the end of the turn
  always_ff @(posedge clk) begin
    result_valid <= 1'b0;
    if (fsm == FSM_PASS && evt.expire && pend) begin
      result_valid     <= 1'b1;
      status_code      <= RC_OK;
      is_expiry        <= 1'b1;
      result_index     <= pend_index;
      expired_callback <= pend_cb;
      expired_tag      <= pend_tag;
      last_result      <= 1'b0;
    end else if (fsm == FSM_FINISH) begin
      result_valid <= 1'b1;
      last_result  <= 1'b1;
      if (pend) begin
        status_code      <= RC_OK;
        is_expiry        <= 1'b1;
        result_index     <= pend_index;
        expired_callback <= pend_cb;
        expired_tag      <= pend_tag;
      end else begin
        status_code      <= status;
        is_expiry        <= 1'b0;
        result_index     <= res_index;
        expired_callback <= 32'd0;
        expired_tag      <= 32'd0;
      end
    end
    if (rst) begin
      result_valid <= 1'b0;
    end
  end

  a_end_beat: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) && !$past(rst) |-> result_valid && last_result)
    else $error("busy dropped without the final result beat");

  a_mid_beat: assert property (@(posedge clk) disable iff (rst)
    result_valid && !last_result |-> busy && is_expiry)
    else $error("non-final beat outside a tick pass");

  a_exp_budget: assert property (@(posedge clk) disable iff (rst)
    exp_cnt <= CNT_W'(MAX_RESULTS))
    else $error("expiry count past its limit");

endmodule

`default_nettype wire

### tb/tb_one_shot_timer_table.sv
// Self-checking testbench for one_shot_timer_table: a table of directed commands, then
// random command traffic, all checked beat by beat against the table rows or a shadow copy of the timers.
// Depends on otst_pkg and the one_shot_timer_table RTL.
module tb_one_shot_timer_table;
  timeunit 1ns;
  timeprecision 1ps;
  import otst_pkg::*;

  localparam int TIMER_SLOTS = 8;
  localparam int N_RANDOM = 433;
  localparam int QUIET_TAIL = 60;
  localparam int DRAIN_CYCLES = 4 * TIMER_SLOTS;
  localparam logic [2:0] REQ_BAD_LO = 3'd5;
  localparam logic [2:0] REQ_BAD_HI = 3'd7;

  typedef struct packed {
    logic [2:0]  status;
    logic        expiry;
    logic [7:0]  index;
    logic [31:0] cb;
    logic [31:0] tag;
    logic        last;
  } beat_t;

  // typed = 1: single beat, status/index read off directly, everything else zero
  typedef struct packed {
    cmd_t       cmd;
    logic       typed;
    logic [2:0] status;
    logic [7:0] index;
  } dir_row_t;

  localparam dir_row_t DIRECTED [27] = '{
    '{'{REQ_TICK,   8'd0,   32'd0, 32'd0, 32'd0}, 1'b1, RC_OK, 8'd0},
    '{'{REQ_ADD,    8'd0,   32'd5, 32'd0, 32'd1234}, 1'b1, RC_BAD_PARAM, 8'd0},
    '{'{REQ_MODIFY, 8'd0,   32'd7, 32'd0, 32'd0}, 1'b1, RC_NO_TIMER, 8'd0},
    '{'{REQ_START,  8'd0,   32'd0, 32'd0, 32'd0}, 1'b1, RC_NOT_READY, 8'd0},
    '{'{REQ_DELETE, 8'd0,   32'd0, 32'd0, 32'd0}, 1'b1, RC_BAD_HANDLE, 8'd0},
    '{'{REQ_MODIFY, 8'd255, 32'd3, 32'd0, 32'd0}, 1'b1, RC_BAD_HANDLE, 8'd0},
    '{'{REQ_START,  8'd8,   32'd0, 32'd0, 32'd0}, 1'b1, RC_BAD_HANDLE, 8'd0},
    '{'{REQ_DELETE, 8'd200, 32'd0, 32'd0, 32'd0}, 1'b1, RC_BAD_HANDLE, 8'd0},
    '{'{REQ_BAD_LO, 8'd0,   32'd0, 32'd1, 32'd0}, 1'b1, RC_BAD_PARAM, 8'd0},
    '{'{REQ_BAD_HI, 8'd255, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF},
      1'b1, RC_BAD_PARAM, 8'd0},
    '{'{REQ_ADD, 8'd0, 32'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, 1'b1, RC_OK, 8'd0},
    '{'{REQ_ADD, 8'd0, 32'd0, 32'd1, 32'd0}, 1'b1, RC_OK, 8'd1},
    '{'{REQ_ADD, 8'd0, 32'hFFFF_FFFF, 32'hA5A5_A5A5, 32'h5A5A_5A5A}, 1'b1, RC_OK, 8'd2},
    '{'{REQ_ADD, 8'd0, 32'd2, 32'd3, 32'd3}, 1'b1, RC_OK, 8'd3},
    '{'{REQ_ADD, 8'd0, 32'd1, 32'd4, 32'd44}, 1'b1, RC_OK, 8'd4},
    '{'{REQ_ADD, 8'd0, 32'd1, 32'd5, 32'd55}, 1'b1, RC_OK, 8'd5},
    '{'{REQ_ADD, 8'd0, 32'd1, 32'd6, 32'd66}, 1'b1, RC_OK, 8'd6},
    '{'{REQ_ADD, 8'd0, 32'd1, 32'd7, 32'd77}, 1'b1, RC_OK, 8'd7},
    '{'{REQ_ADD, 8'd0, 32'd1, 32'd9, 32'd99}, 1'b1, RC_NO_TIMER, 8'd0},
    '{'{REQ_MODIFY, 8'd3, 32'd1, 32'd0, 32'd0}, 1'b1, RC_OK, 8'd0},
    '{'{REQ_START, 8'd0, 32'd0, 32'd0, 32'd0}, 1'b1, RC_OK, 8'd0},
    '{'{REQ_START, 8'd1, 32'd0, 32'd0, 32'd0}, 1'b1, RC_OK, 8'd0},
    '{'{REQ_START, 8'd2, 32'd0, 32'd0, 32'd0}, 1'b1, RC_OK, 8'd0},
    '{'{REQ_START, 8'd0, 32'd0, 32'd0, 32'd0}, 1'b1, RC_NOT_READY, 8'd0},
    // slot 0 expires, slot 1 (zero ticks) wraps, slot 2 counts down from max
    '{'{REQ_TICK,   8'd0, 32'd0, 32'd0, 32'd0}, 1'b0, RC_OK, 8'd0},
    '{'{REQ_DELETE, 8'd2, 32'd0, 32'd0, 32'd0}, 1'b1, RC_OK, 8'd0},
    '{'{REQ_TICK,   8'd0, 32'd0, 32'd0, 32'd0}, 1'b0, RC_OK, 8'd0}
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [2:0]  req_type = '0;
  logic [7:0]  timer_index = '0;
  logic [31:0] tick_count = '0;
  logic [31:0] callback_id = '0;
  logic [31:0] user_tag = '0;
  logic        result_valid;
  logic [2:0]  status_code;
  logic        is_expiry;
  logic [7:0]  result_index;
  logic [31:0] expired_callback;
  logic [31:0] expired_tag;
  logic        last_result;

  // shadow copy of the timer table
  slot_state_t shadow_state [TIMER_SLOTS];
  logic [31:0] shadow_ticks [TIMER_SLOTS];
  logic [31:0] shadow_cb    [TIMER_SLOTS];
  logic [31:0] shadow_tag   [TIMER_SLOTS];

  beat_t expected_beats [$];
  int    mismatches = 0;

  one_shot_timer_table #(.TIMER_SLOTS(TIMER_SLOTS)) uut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  task automatic clear_shadow_slot(input int s);
    shadow_state[s] = SLOT_IDLE;
    shadow_ticks[s] = '0;
    shadow_cb[s]    = '0;
    shadow_tag[s]   = '0;
  endtask

  // apply one command to the shadow table and queue the beats it should produce
  task automatic predict_timer_results(input cmd_t c);
    beat_t hits [MAX_RESULTS];
    beat_t b;
    int n;
    logic found;
    b = '0;
    b.last = 1'b1;
    if (c.req == REQ_TICK) begin
      n = 0;
      for (int s = 0; s < TIMER_SLOTS; s++) begin
        // a slot due now waits for a later tick once the beat budget is spent
        if (shadow_state[s] == SLOT_RUN && !(shadow_ticks[s] == 32'd1 && n >= MAX_RESULTS))
        begin
          shadow_ticks[s] = shadow_ticks[s] - 32'd1;
          if (shadow_ticks[s] == '0) begin
            hits[n] = '0;
            hits[n].status = RC_OK;
            hits[n].expiry = 1'b1;
            hits[n].index = 8'(s);
            hits[n].cb = shadow_cb[s];
            hits[n].tag = shadow_tag[s];
            n++;
            clear_shadow_slot(s);
          end
        end
      end
      if (n == 0) begin
        b.status = RC_OK;
        expected_beats.push_back(b);
      end else begin
        hits[n-1].last = 1'b1;
        for (int k = 0; k < n; k++) expected_beats.push_back(hits[k]);
      end
    end else begin
      case (c.req)
        REQ_ADD: begin
          if (c.cb == '0) begin
            b.status = RC_BAD_PARAM;
          end else begin
            found = 1'b0;
            for (int s = 0; s < TIMER_SLOTS; s++) begin
              if (!found && shadow_state[s] == SLOT_IDLE) begin
                found = 1'b1;
                shadow_state[s] = SLOT_READY;
                shadow_ticks[s] = c.ticks;
                shadow_cb[s] = c.cb;
                shadow_tag[s] = c.tag;
                b.index = 8'(s);
              end
            end
            b.status = found ? RC_OK : RC_NO_TIMER;
          end
        end
        REQ_MODIFY, REQ_START, REQ_DELETE: begin
          b.status = RC_OK;
          if (c.idx >= TIMER_SLOTS) begin
            b.status = RC_BAD_HANDLE;
          end else if (c.req == REQ_MODIFY) begin
            if (shadow_state[c.idx] == SLOT_IDLE) b.status = RC_NO_TIMER;
            else shadow_ticks[c.idx] = c.ticks;
          end else if (c.req == REQ_START) begin
            if (shadow_state[c.idx] != SLOT_READY) b.status = RC_NOT_READY;
            else shadow_state[c.idx] = SLOT_RUN;
          end else begin
            if (shadow_state[c.idx] == SLOT_IDLE) b.status = RC_BAD_HANDLE;
            else clear_shadow_slot(c.idx);
          end
        end
        default: b.status = RC_BAD_PARAM;
      endcase
      expected_beats.push_back(b);
    end
  endtask

  // drive one command beat and hold it until the block takes it
  task automatic send_cmd(input cmd_t c, input bit typed, input beat_t want);
    start       <= 1'b1;
    req_type    <= c.req;
    timer_index <= c.idx;
    tick_count  <= c.ticks;
    callback_id <= c.cb;
    user_tag    <= c.tag;
    do @(posedge clk); while (busy);
    predict_timer_results(c);
    if (typed) begin
      void'(expected_beats.pop_back());
      expected_beats.push_back(want);
    end
  endtask

  task automatic idle_sender(input int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  function automatic cmd_t random_cmd();
    cmd_t c;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 25)      c.req = REQ_ADD;
    else if (pick < 35) c.req = REQ_MODIFY;
    else if (pick < 57) c.req = REQ_START;
    else if (pick < 67) c.req = REQ_DELETE;
    else if (pick < 95) c.req = REQ_TICK;
    else                c.req = 3'($urandom_range(REQ_BAD_LO, REQ_BAD_HI));
    c.idx   = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, TIMER_SLOTS - 1));
    // short delays keep expiries frequent; full-range values exercise all bits
    c.ticks = ($urandom_range(0, 7) == 0) ? 32'($urandom) : 32'($urandom_range(0, 4));
    c.cb    = ($urandom_range(0, 15) == 0) ? 32'd0 : 32'($urandom);
    c.tag   = 32'($urandom);
    return c;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    beat_t want;
    if (!rst && result_valid) begin
      if (expected_beats.size() == 0) begin
        $error("result beat with nothing expected (status %0d, index %0d)",
               status_code, result_index);
        mismatches++;
      end else begin
        want = expected_beats.pop_front();
        check_field("status_code", 32'(want.status), 32'(status_code));
        check_field("is_expiry", 32'(want.expiry), 32'(is_expiry));
        check_field("result_index", 32'(want.index), 32'(result_index));
        check_field("expired_callback", want.cb, expired_callback);
        check_field("expired_tag", want.tag, expired_tag);
        check_field("last_result", 32'(want.last), 32'(last_result));
      end
    end
  end

  initial begin
    #2ms;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    dir_row_t row;
    beat_t want;
    cmd_t c;
    int i;
    for (int s = 0; s < TIMER_SLOTS; s++) clear_shadow_slot(s);
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (DIRECTED[k]) begin
      row = DIRECTED[k];
      want = '0;
      want.status = row.status;
      want.index = row.index;
      want.last = 1'b1;
      send_cmd(row.cmd, row.typed, want);
      if ($urandom_range(0, 3) == 0) idle_sender($urandom_range(1, 12));
    end

    i = 0;
    while (i < N_RANDOM) begin
      if (i == 120 || i == 300) begin
        // clear the table, arm every slot for one tick: a full burst of expiries
        for (int s = 0; s < TIMER_SLOTS; s++) begin
          c = '{REQ_DELETE, 8'(s), 32'($urandom), 32'($urandom), 32'($urandom)};
          send_cmd(c, 1'b0, '0);
        end
        for (int s = 0; s < TIMER_SLOTS; s++) begin
          c = '{REQ_ADD, 8'($urandom), 32'd1, 32'($urandom) | 32'd1, 32'($urandom)};
          send_cmd(c, 1'b0, '0);
        end
        for (int s = 0; s < TIMER_SLOTS; s++) begin
          c = '{REQ_START, 8'(s), 32'($urandom), 32'($urandom), 32'($urandom)};
          send_cmd(c, 1'b0, '0);
        end
        c = '{REQ_TICK, 8'($urandom), 32'($urandom), 32'($urandom), 32'($urandom)};
        send_cmd(c, 1'b0, '0);
        i += 3 * TIMER_SLOTS + 1;
      end else begin
        if (i == 220) begin
          // let the block drain completely before going on
          start <= 1'b0;
          do @(posedge clk); while (expected_beats.size() != 0);
        end
        send_cmd(random_cmd(), 1'b0, '0);
        i++;
      end
      if (i < N_RANDOM - QUIET_TAIL && $urandom_range(0, 3) == 0)
        idle_sender($urandom_range(1, 12));
    end

    start <= 1'b0;
    do @(posedge clk); while (expected_beats.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

### one_shot_timer_table.f
rtl/otst_pkg.sv
rtl/otst_cell.sv
rtl/otst_proc.sv
rtl/one_shot_timer_table.sv
tb/tb_one_shot_timer_table.sv
